### rtl/spot_pkg.sv
package spot_pkg;

  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned KindWidth     = 2;

  localparam logic [KindWidth-1:0] KindCircle = 2'd0;
  localparam logic [KindWidth-1:0] KindRect   = 2'd1;
  localparam logic [KindWidth-1:0] KindSeg    = 2'd2;

endpackage

### rtl/spot_if.sv
interface spot_in_if #(
  parameter int unsigned CoordWidth = spot_pkg::CoordWidthDef
) ();
  logic                              valid;
  logic                              ready;
  logic [spot_pkg::KindWidth-1:0]    a_kind;
  logic signed [CoordWidth-1:0]      a_x;
  logic signed [CoordWidth-1:0]      a_y;
  logic signed [CoordWidth-1:0]      a_p;
  logic signed [CoordWidth-1:0]      a_q;
  logic [spot_pkg::KindWidth-1:0]    b_kind;
  logic signed [CoordWidth-1:0]      b_x;
  logic signed [CoordWidth-1:0]      b_y;
  logic signed [CoordWidth-1:0]      b_p;
  logic signed [CoordWidth-1:0]      b_q;

  modport source (
    output valid, a_kind, a_x, a_y, a_p, a_q, b_kind, b_x, b_y, b_p, b_q,
    input  ready
  );
  modport sink (
    input  valid, a_kind, a_x, a_y, a_p, a_q, b_kind, b_x, b_y, b_p, b_q,
    output ready
  );
endinterface

interface spot_out_if ();
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

### rtl/shape_pair_overlap_test.sv
// Channel   Dir   Payload                                        Word accepted
// in_i      in    a_kind a_x a_y a_p a_q b_kind b_x b_y b_p b_q  valid & ready
// out_o     out   overlap                                        valid & ready
//
// One pair per cycle unless out_o stalls, through s0_q to s5_q and overlap_q.
// Latency is set by the circle-segment cross-product compare, whose squared
// terms are split into half-width partial products and summed a stage later.
// Reset clears the stage valid bits only; the datapath registers have no reset.
// Each stage holds while the one after it is full and stalled, so bubbles
// are squeezed out and the input stays ready until all seven stages are full.
module shape_pair_overlap_test #(
  parameter int unsigned COORD_WIDTH = spot_pkg::CoordWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spot_in_if.sink   in_i,
  spot_out_if.source out_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned EW = W + 1;
  localparam int unsigned DW = W + 2;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned HW = (SW + 1) / 2;
  localparam int unsigned FW = 4 * HW;
  localparam int unsigned NS = 7;

  // point order per group: first seg start, end, second seg start, end
  localparam int unsigned IdxA [4] = '{0, 1, 0, 0};
  localparam int unsigned IdxB [4] = '{2, 2, 1, 1};
  localparam int unsigned IdxC [4] = '{3, 3, 2, 3};

  typedef enum logic [2:0] {
    ModeNone, ModeCc, ModeCr, ModeCs, ModeRr, ModeRs, ModeSs
  } mode_e;

  typedef logic signed [EW-1:0] ext_t;
  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [PW-1:0] prd_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic [2*HW-1:0]      pp_t;

  typedef struct {
    mode_e mode;
    ext_t  ux, uy, up, uq, vx, vy, vp, vq, uex, uey, vex, vey;
  } s0_t;

  typedef struct {
    mode_e mode;
    logic  rr_hit;
    logic  ins;
    dif_t  od [4][4][4];
    dif_t  fx, fy, gx, gy, dx, dy, rr;
  } s1_t;

  typedef struct {
    mode_e mode;
    logic  rr_hit;
    logic  ins;
    prd_t  op [4][4][2];
    prd_t  sfx, sfy, sgx, sgy, sdx, sdy, fxdx, fydy, fxdy, fydx, r2;
  } s2_t;

  typedef struct {
    mode_e mode;
    logic  rr_hit;
    logic  ins;
    logic  o [4][4];
    sum_t  sqf, sqg, len2, dot, cr;
    prd_t  r2;
  } s3_t;

  typedef struct {
    logic res;
    logic use_cr;
    pp_t  c_hh, c_hl, c_ll, r_hh, r_hl, r_lh, r_ll;
  } s4_t;

  typedef struct {
    logic          res;
    logic          use_cr;
    logic [FW-1:0] crsq, rlsq;
  } s5_t;

  logic [NS-1:0] v_q, v_d, en;

  s0_t  s0_d, s0_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  s5_t  s5_d, s5_q;
  logic overlap_d, overlap_q;

  // handshake: a stage loads when empty or when the next one loads
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_i.valid : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  assign in_i.ready    = en[0];
  assign out_o.valid   = v_q[NS-1];
  assign out_o.overlap = overlap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage 0: order the pair by kind, form rectangle far corners
  logic                              swap;
  logic [spot_pkg::KindWidth-1:0]    k_lo, k_hi;

  always_comb begin
    swap = in_i.a_kind > in_i.b_kind;
    k_lo = swap ? in_i.b_kind : in_i.a_kind;
    k_hi = swap ? in_i.a_kind : in_i.b_kind;
    case ({k_lo, k_hi})
      {spot_pkg::KindCircle, spot_pkg::KindCircle}: s0_d.mode = ModeCc;
      {spot_pkg::KindCircle, spot_pkg::KindRect}:   s0_d.mode = ModeCr;
      {spot_pkg::KindCircle, spot_pkg::KindSeg}:    s0_d.mode = ModeCs;
      {spot_pkg::KindRect, spot_pkg::KindRect}:     s0_d.mode = ModeRr;
      {spot_pkg::KindRect, spot_pkg::KindSeg}:      s0_d.mode = ModeRs;
      {spot_pkg::KindSeg, spot_pkg::KindSeg}:       s0_d.mode = ModeSs;
      default:                                      s0_d.mode = ModeNone;
    endcase
    s0_d.ux  = EW'(swap ? in_i.b_x : in_i.a_x);
    s0_d.uy  = EW'(swap ? in_i.b_y : in_i.a_y);
    s0_d.up  = EW'(swap ? in_i.b_p : in_i.a_p);
    s0_d.uq  = EW'(swap ? in_i.b_q : in_i.a_q);
    s0_d.vx  = EW'(swap ? in_i.a_x : in_i.b_x);
    s0_d.vy  = EW'(swap ? in_i.a_y : in_i.b_y);
    s0_d.vp  = EW'(swap ? in_i.a_p : in_i.b_p);
    s0_d.vq  = EW'(swap ? in_i.a_q : in_i.b_q);
    s0_d.uex = s0_d.ux + s0_d.up;
    s0_d.uey = s0_d.uy + s0_d.uq;
    s0_d.vex = s0_d.vx + s0_d.vp;
    s0_d.vey = s0_d.vy + s0_d.vq;
  end

  // stage 1: interval tests, clamp, point selection and differences
  ext_t pt_x [4][4];
  ext_t pt_y [4][4];
  ext_t cl_x, cl_y;
  logic seg_pair;

  always_comb begin
    seg_pair = s0_q.mode == ModeSs;
    for (int g = 0; g < 4; g++) begin
      pt_x[g][0] = s0_q.vx;
      pt_y[g][0] = s0_q.vy;
      pt_x[g][1] = s0_q.vp;
      pt_y[g][1] = s0_q.vq;
    end
    if (seg_pair) begin
      pt_x[0][0] = s0_q.ux;
      pt_y[0][0] = s0_q.uy;
      pt_x[0][1] = s0_q.up;
      pt_y[0][1] = s0_q.uq;
      pt_x[0][2] = s0_q.vx;
      pt_y[0][2] = s0_q.vy;
      pt_x[0][3] = s0_q.vp;
      pt_y[0][3] = s0_q.vq;
    end else begin
      // top edge
      pt_x[0][2] = s0_q.ux;
      pt_y[0][2] = s0_q.uy;
      pt_x[0][3] = s0_q.uex;
      pt_y[0][3] = s0_q.uy;
    end
    // left edge
    pt_x[1][2] = s0_q.ux;
    pt_y[1][2] = s0_q.uy;
    pt_x[1][3] = s0_q.ux;
    pt_y[1][3] = s0_q.uey;
    // right edge
    pt_x[2][2] = s0_q.uex;
    pt_y[2][2] = s0_q.uy;
    pt_x[2][3] = s0_q.uex;
    pt_y[2][3] = s0_q.uey;
    // bottom edge
    pt_x[3][2] = s0_q.ux;
    pt_y[3][2] = s0_q.uey;
    pt_x[3][3] = s0_q.uex;
    pt_y[3][3] = s0_q.uey;

    s1_d.mode   = s0_q.mode;
    s1_d.rr_hit = !(s0_q.uex < s0_q.vx || s0_q.vex < s0_q.ux ||
                    s0_q.uey < s0_q.vy || s0_q.vey < s0_q.uy);
    s1_d.ins    = (s0_q.vx >= s0_q.ux && s0_q.vx <= s0_q.uex &&
                   s0_q.vy >= s0_q.uy && s0_q.vy <= s0_q.uey) ||
                  (s0_q.vp >= s0_q.ux && s0_q.vp <= s0_q.uex &&
                   s0_q.vq >= s0_q.uy && s0_q.vq <= s0_q.uey);

    for (int g = 0; g < 4; g++) begin
      for (int k = 0; k < 4; k++) begin
        s1_d.od[g][k][0] = DW'(pt_y[g][IdxC[k]]) - DW'(pt_y[g][IdxA[k]]);
        s1_d.od[g][k][1] = DW'(pt_x[g][IdxB[k]]) - DW'(pt_x[g][IdxA[k]]);
        s1_d.od[g][k][2] = DW'(pt_y[g][IdxB[k]]) - DW'(pt_y[g][IdxA[k]]);
        s1_d.od[g][k][3] = DW'(pt_x[g][IdxC[k]]) - DW'(pt_x[g][IdxA[k]]);
      end
    end

    // closest point of the rectangle to the circle centre
    cl_x = (s0_q.ux < s0_q.vx) ? s0_q.vx : ((s0_q.ux > s0_q.vex) ? s0_q.vex : s0_q.ux);
    cl_y = (s0_q.uy < s0_q.vy) ? s0_q.vy : ((s0_q.uy > s0_q.vey) ? s0_q.vey : s0_q.uy);

    if (s0_q.mode == ModeCr) begin
      s1_d.fx = DW'(s0_q.ux) - DW'(cl_x);
      s1_d.fy = DW'(s0_q.uy) - DW'(cl_y);
    end else begin
      s1_d.fx = DW'(s0_q.ux) - DW'(s0_q.vx);
      s1_d.fy = DW'(s0_q.uy) - DW'(s0_q.vy);
    end
    s1_d.gx = DW'(s0_q.ux) - DW'(s0_q.vp);
    s1_d.gy = DW'(s0_q.uy) - DW'(s0_q.vq);
    s1_d.dx = DW'(s0_q.vp) - DW'(s0_q.vx);
    s1_d.dy = DW'(s0_q.vq) - DW'(s0_q.vy);
    s1_d.rr = (s0_q.mode == ModeCc) ? DW'(s0_q.up) + DW'(s0_q.vp) : DW'(s0_q.up);
  end

  // stage 2: products
  always_comb begin
    s2_d.mode   = s1_q.mode;
    s2_d.rr_hit = s1_q.rr_hit;
    s2_d.ins    = s1_q.ins;
    for (int g = 0; g < 4; g++) begin
      for (int k = 0; k < 4; k++) begin
        s2_d.op[g][k][0] = PW'(s1_q.od[g][k][0]) * PW'(s1_q.od[g][k][1]);
        s2_d.op[g][k][1] = PW'(s1_q.od[g][k][2]) * PW'(s1_q.od[g][k][3]);
      end
    end
    s2_d.sfx  = PW'(s1_q.fx) * PW'(s1_q.fx);
    s2_d.sfy  = PW'(s1_q.fy) * PW'(s1_q.fy);
    s2_d.sgx  = PW'(s1_q.gx) * PW'(s1_q.gx);
    s2_d.sgy  = PW'(s1_q.gy) * PW'(s1_q.gy);
    s2_d.sdx  = PW'(s1_q.dx) * PW'(s1_q.dx);
    s2_d.sdy  = PW'(s1_q.dy) * PW'(s1_q.dy);
    s2_d.fxdx = PW'(s1_q.fx) * PW'(s1_q.dx);
    s2_d.fydy = PW'(s1_q.fy) * PW'(s1_q.dy);
    s2_d.fxdy = PW'(s1_q.fx) * PW'(s1_q.dy);
    s2_d.fydx = PW'(s1_q.fy) * PW'(s1_q.dx);
    s2_d.r2   = PW'(s1_q.rr) * PW'(s1_q.rr);
  end

  // stage 3: orientation compares and sums
  always_comb begin
    s3_d.mode   = s2_q.mode;
    s3_d.rr_hit = s2_q.rr_hit;
    s3_d.ins    = s2_q.ins;
    for (int g = 0; g < 4; g++) begin
      for (int k = 0; k < 4; k++) begin
        s3_d.o[g][k] = s2_q.op[g][k][0] > s2_q.op[g][k][1];
      end
    end
    s3_d.sqf  = SW'(s2_q.sfx) + SW'(s2_q.sfy);
    s3_d.sqg  = SW'(s2_q.sgx) + SW'(s2_q.sgy);
    s3_d.len2 = SW'(s2_q.sdx) + SW'(s2_q.sdy);
    s3_d.dot  = SW'(s2_q.fxdx) + SW'(s2_q.fydy);
    s3_d.cr   = SW'(s2_q.fxdy) - SW'(s2_q.fydx);
    s3_d.r2   = s2_q.r2;
  end

  // stage 4: decide all but the segment interior case, split wide squares
  logic [3:0] seg_hit;
  logic       near, far, hit_f, hit_g;
  pp_t        cm, ra, lb;
  logic [HW-1:0] ch, cl, ah, al, bh, bl;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      seg_hit[g] = (s3_q.o[g][0] != s3_q.o[g][1]) && (s3_q.o[g][2] != s3_q.o[g][3]);
    end
    near  = (s3_q.len2 == '0) || s3_q.dot[SW-1] || (s3_q.dot == '0);
    far   = s3_q.dot >= s3_q.len2;
    hit_f = s3_q.sqf <= SW'(s3_q.r2);
    hit_g = s3_q.sqg <= SW'(s3_q.r2);

    case (s3_q.mode)
      ModeCc, ModeCr: s4_d.res = hit_f;
      ModeCs:         s4_d.res = near ? hit_f : hit_g;
      ModeRr:         s4_d.res = s3_q.rr_hit;
      ModeRs:         s4_d.res = s3_q.ins || (|seg_hit);
      ModeSs:         s4_d.res = seg_hit[0];
      default:        s4_d.res = 1'b0;
    endcase
    s4_d.use_cr = (s3_q.mode == ModeCs) && !near && !far;

    cm = (2*HW)'(s3_q.cr[SW-1] ? -s3_q.cr : s3_q.cr);
    ra = (2*HW)'(s3_q.r2);
    lb = (2*HW)'(s3_q.len2);
    ch = cm[2*HW-1:HW];
    cl = cm[HW-1:0];
    ah = ra[2*HW-1:HW];
    al = ra[HW-1:0];
    bh = lb[2*HW-1:HW];
    bl = lb[HW-1:0];

    s4_d.c_hh = (2*HW)'(ch) * (2*HW)'(ch);
    s4_d.c_hl = (2*HW)'(ch) * (2*HW)'(cl);
    s4_d.c_ll = (2*HW)'(cl) * (2*HW)'(cl);
    s4_d.r_hh = (2*HW)'(ah) * (2*HW)'(bh);
    s4_d.r_hl = (2*HW)'(ah) * (2*HW)'(bl);
    s4_d.r_lh = (2*HW)'(al) * (2*HW)'(bh);
    s4_d.r_ll = (2*HW)'(al) * (2*HW)'(bl);
  end

  // stage 5: assemble squared cross product and radius-length product
  always_comb begin
    s5_d.res    = s4_q.res;
    s5_d.use_cr = s4_q.use_cr;
    s5_d.crsq   = (FW'(s4_q.c_hh) << (2*HW)) + (FW'(s4_q.c_hl) << (HW+1)) +
                  FW'(s4_q.c_ll);
    s5_d.rlsq   = (FW'(s4_q.r_hh) << (2*HW)) +
                  ((FW'(s4_q.r_hl) + FW'(s4_q.r_lh)) << HW) + FW'(s4_q.r_ll);
  end

  // stage 6: final compare into the output register
  assign overlap_d = s5_q.use_cr ? (s5_q.crsq <= s5_q.rlsq) : s5_q.res;

  always_ff @(posedge clk_i) begin
    if (en[0]) s0_q <= s0_d;
    if (en[1]) s1_q <= s1_d;
    if (en[2]) s2_q <= s2_d;
    if (en[3]) s3_q <= s3_d;
    if (en[4]) s4_q <= s4_d;
    if (en[5]) s5_q <= s5_d;
    if (en[6]) overlap_q <= overlap_d;
  end

endmodule

### bench/shape_pair_overlap_test_tb.sv
module shape_pair_overlap_test_tb;

  localparam int unsigned CW = 16;
  localparam logic [spot_pkg::KindWidth-1:0] KindNone = 2'd3;

  typedef logic signed [127:0] wide_t;
  typedef longint shape_t [4];

  typedef struct {
    logic [spot_pkg::KindWidth-1:0] a_kind;
    logic signed [CW-1:0] a_x, a_y, a_p, a_q;
    logic [spot_pkg::KindWidth-1:0] b_kind;
    logic signed [CW-1:0] b_x, b_y, b_p, b_q;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spot_in_if #(.CoordWidth(CW)) pair_if ();
  spot_out_if flag_if ();

  shape_pair_overlap_test #(.COORD_WIDTH(CW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pair_if),
    .out_o  (flag_if)
  );

  pair_t pair_queue[$];
  bit    overlap_due_q[$];
  int    mismatch_cnt = 0;
  int    flags_seen = 0;
  int    n_items;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic wide_t wmul(wide_t a, wide_t b);
    return a * b;
  endfunction

  function automatic wide_t sq_len(longint dx, longint dy);
    wide_t wx, wy;
    wx = dx;
    wy = dy;
    return wx * wx + wy * wy;
  endfunction

  function automatic bit turns_left(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
    return wmul(cy - ay, bx - ax) > wmul(by - ay, cx - ax);
  endfunction

  function automatic bit segs_cross(shape_t s, shape_t t);
    bit o1, o2, o3, o4;
    o1 = turns_left(s[0], s[1], t[0], t[1], t[2], t[3]);
    o2 = turns_left(s[2], s[3], t[0], t[1], t[2], t[3]);
    o3 = turns_left(s[0], s[1], s[2], s[3], t[0], t[1]);
    o4 = turns_left(s[0], s[1], s[2], s[3], t[2], t[3]);
    return (o1 != o2) && (o3 != o4);
  endfunction

  function automatic bit circles_hit(shape_t c, shape_t d);
    longint rs;
    rs = c[2] + d[2];
    return sq_len(c[0] - d[0], c[1] - d[1]) <= wmul(rs, rs);
  endfunction

  function automatic bit rects_hit(shape_t r, shape_t s);
    return !(r[0] + r[2] < s[0] || s[0] + s[2] < r[0] ||
             r[1] + r[3] < s[1] || s[1] + s[3] < r[1]);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit circle_rect_hit(shape_t c, shape_t r);
    longint px, py;
    px = clamp(c[0], r[0], r[0] + r[2]);
    py = clamp(c[1], r[1], r[1] + r[3]);
    return sq_len(c[0] - px, c[1] - py) <= wmul(c[2], c[2]);
  endfunction

  function automatic bit circle_seg_hit(shape_t c, shape_t l);
    longint dx, dy, fx, fy;
    wide_t r2, len2, dot, cr;
    dx = l[2] - l[0];
    dy = l[3] - l[1];
    fx = c[0] - l[0];
    fy = c[1] - l[1];
    r2 = wmul(c[2], c[2]);
    len2 = sq_len(dx, dy);
    dot = wmul(fx, dx) + wmul(fy, dy);
    // zero-length segment degenerates to a point
    if (len2 == 0 || dot <= 0) return sq_len(fx, fy) <= r2;
    if (dot >= len2) return sq_len(c[0] - l[2], c[1] - l[3]) <= r2;
    cr = wmul(fx, dy) - wmul(fy, dx);
    return cr * cr <= r2 * len2;
  endfunction

  function automatic bit in_rect(longint px, longint py, shape_t r);
    return px >= r[0] && px <= r[0] + r[2] && py >= r[1] && py <= r[1] + r[3];
  endfunction

  function automatic bit rect_seg_hit(shape_t r, shape_t l);
    longint x0, y0, x1, y1;
    shape_t e_top, e_left, e_right, e_bot;
    x0 = r[0];
    y0 = r[1];
    x1 = r[0] + r[2];
    y1 = r[1] + r[3];
    if (in_rect(l[0], l[1], r) || in_rect(l[2], l[3], r)) return 1'b1;
    e_top   = '{x0, y0, x1, y0};
    e_left  = '{x0, y0, x0, y1};
    e_right = '{x1, y0, x1, y1};
    e_bot   = '{x0, y1, x1, y1};
    return segs_cross(l, e_top) || segs_cross(l, e_left) ||
           segs_cross(l, e_right) || segs_cross(l, e_bot);
  endfunction

  function automatic bit pair_overlap(pair_t it);
    shape_t a, b;
    a = '{it.a_x, it.a_y, it.a_p, it.a_q};
    b = '{it.b_x, it.b_y, it.b_p, it.b_q};
    case (it.a_kind)
      spot_pkg::KindCircle:
        case (it.b_kind)
          spot_pkg::KindCircle: return circles_hit(a, b);
          spot_pkg::KindRect:   return circle_rect_hit(a, b);
          spot_pkg::KindSeg:    return circle_seg_hit(a, b);
          default:              return 1'b0;
        endcase
      spot_pkg::KindRect:
        case (it.b_kind)
          spot_pkg::KindCircle: return circle_rect_hit(b, a);
          spot_pkg::KindRect:   return rects_hit(a, b);
          spot_pkg::KindSeg:    return rect_seg_hit(a, b);
          default:              return 1'b0;
        endcase
      spot_pkg::KindSeg:
        case (it.b_kind)
          spot_pkg::KindCircle: return circle_seg_hit(b, a);
          spot_pkg::KindRect:   return rect_seg_hit(b, a);
          spot_pkg::KindSeg:    return segs_cross(a, b);
          default:              return 1'b0;
        endcase
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic add_pair(logic [1:0] ak, int ax, int ay, int ap, int aq,
                          logic [1:0] bk, int bx, int by, int bp, int bq);
    pair_t it;
    it.a_kind = ak;
    it.a_x = CW'(ax);
    it.a_y = CW'(ay);
    it.a_p = CW'(ap);
    it.a_q = CW'(aq);
    it.b_kind = bk;
    it.b_x = CW'(bx);
    it.b_y = CW'(by);
    it.b_p = CW'(bp);
    it.b_q = CW'(bq);
    pair_queue.push_back(it);
  endtask

  function automatic logic [1:0] rnd_kind();
    return ($urandom_range(0, 19) == 0) ? KindNone : 2'($urandom_range(0, 2));
  endfunction

  function automatic int rnd_pos();
    case ($urandom_range(0, 9))
      0:       return int'($urandom() & 16'hffff) - 32768;
      1:       return int'($urandom_range(0, 16000)) - 8000;
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic int rnd_size();
    case ($urandom_range(0, 9))
      0:       return int'($urandom() & 16'hffff) - 32768;
      1:       return -int'($urandom_range(0, 400));
      default: return int'($urandom_range(0, 900));
    endcase
  endfunction

  function automatic int rnd_gap();
    case ($urandom_range(0, 19))
      0:               return $urandom_range(15, 60);
      1, 2, 3, 4:      return $urandom_range(1, 3);
      default:         return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver
  int in_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_if.valid  <= 1'b0;
      pair_if.a_kind <= '0;
      pair_if.a_x    <= '0;
      pair_if.a_y    <= '0;
      pair_if.a_p    <= '0;
      pair_if.a_q    <= '0;
      pair_if.b_kind <= '0;
      pair_if.b_x    <= '0;
      pair_if.b_y    <= '0;
      pair_if.b_p    <= '0;
      pair_if.b_q    <= '0;
      in_gap         <= 0;
    end else begin
      if (pair_if.valid && pair_if.ready) begin
        pair_t cur;
        cur.a_kind = pair_if.a_kind;
        cur.a_x = pair_if.a_x;
        cur.a_y = pair_if.a_y;
        cur.a_p = pair_if.a_p;
        cur.a_q = pair_if.a_q;
        cur.b_kind = pair_if.b_kind;
        cur.b_x = pair_if.b_x;
        cur.b_y = pair_if.b_y;
        cur.b_p = pair_if.b_p;
        cur.b_q = pair_if.b_q;
        overlap_due_q.push_back(pair_overlap(cur));
      end
      if (pair_if.valid && !pair_if.ready) begin
        // hold the word until taken
      end else if (in_gap > 0) begin
        in_gap        <= in_gap - 1;
        pair_if.valid <= 1'b0;
      end else if (pair_queue.size() > 0) begin
        pair_t nxt;
        nxt = pair_queue.pop_front();
        pair_if.valid  <= 1'b1;
        pair_if.a_kind <= nxt.a_kind;
        pair_if.a_x    <= nxt.a_x;
        pair_if.a_y    <= nxt.a_y;
        pair_if.a_p    <= nxt.a_p;
        pair_if.a_q    <= nxt.a_q;
        pair_if.b_kind <= nxt.b_kind;
        pair_if.b_x    <= nxt.b_x;
        pair_if.b_y    <= nxt.b_y;
        pair_if.b_p    <= nxt.b_p;
        pair_if.b_q    <= nxt.b_q;
        in_gap         <= rnd_gap();
      end else begin
        pair_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int  out_gap;
  int  hold_off;
  bit  hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_if.ready <= 1'b0;
      out_gap       <= 0;
      hold_off      <= 0;
      hold_done     <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off      <= hold_off - 1;
      flag_if.ready <= 1'b0;
    end else if (!hold_done && flags_seen >= 300) begin
      // long stall so the pipeline fills and backs up into the input
      hold_done     <= 1'b1;
      hold_off      <= 400;
      flag_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap       <= out_gap - 1;
      flag_if.ready <= 1'b0;
    end else begin
      flag_if.ready <= 1'b1;
      out_gap       <= (flags_seen > 600 && flags_seen < 750) ? 0 : rnd_gap();
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni && flag_if.valid && flag_if.ready) begin
      flags_seen <= flags_seen + 1;
      if (overlap_due_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10)
          $display("overlap word %0d with no pair pending: got %0b", flags_seen,
                   flag_if.overlap);
      end else begin
        bit want;
        want = overlap_due_q.pop_front();
        if (flag_if.overlap !== want) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("overlap word %0d: expected %0b, got %0b", flags_seen, want,
                     flag_if.overlap);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_ni = 1'b0;

    add_pair(spot_pkg::KindCircle, 0, 0, 160, 0, spot_pkg::KindCircle, 300, 0, 140, 0);
    add_pair(spot_pkg::KindCircle, 0, 0, -160, 7, spot_pkg::KindCircle, 320, 0, -160, 0);
    add_pair(spot_pkg::KindCircle, 0, 0, 100, 0, spot_pkg::KindRect, 50, 50, 200, 200);
    add_pair(spot_pkg::KindRect, 0, 0, 100, 100, spot_pkg::KindCircle, 300, 300, 50, 0);
    add_pair(spot_pkg::KindCircle, 0, 0, 50, 0, spot_pkg::KindSeg, -100, 40, 100, 40);
    add_pair(spot_pkg::KindSeg, 10, 10, 10, 10, spot_pkg::KindCircle, 0, 0, 20, 0);
    add_pair(spot_pkg::KindRect, 0, 0, 100, 100, spot_pkg::KindRect, 100, 100, 10, 10);
    add_pair(spot_pkg::KindRect, 0, 0, -100, 100, spot_pkg::KindRect, -50, 0, 10, 10);
    add_pair(spot_pkg::KindRect, 0, 0, 100, 100, spot_pkg::KindSeg, -50, 50, 150, 50);
    add_pair(spot_pkg::KindSeg, -50, -50, -10, -10, spot_pkg::KindRect, 0, 0, 100, 100);
    add_pair(spot_pkg::KindSeg, 0, 0, 100, 100, spot_pkg::KindSeg, 0, 100, 100, 0);
    add_pair(spot_pkg::KindSeg, 0, 0, 100, 0, spot_pkg::KindSeg, 50, 0, 200, 0);
    add_pair(spot_pkg::KindSeg, 0, 0, 100, 0, spot_pkg::KindSeg, 100, 0, 100, 100);
    add_pair(KindNone, 0, 0, 100, 100, spot_pkg::KindCircle, 0, 0, 100, 0);
    add_pair(spot_pkg::KindCircle, 0, 0, 100, 0, KindNone, 0, 0, 100, 100);
    add_pair(spot_pkg::KindCircle, 32767, 32767, 32767, 32767,
             spot_pkg::KindCircle, -32768, -32768, -32768, -32768);
    add_pair(spot_pkg::KindSeg, -32768, -32768, 32767, 32767,
             spot_pkg::KindCircle, 32767, -32768, 32767, 0);
    add_pair(spot_pkg::KindRect, -32768, -32768, 32767, 32767,
             spot_pkg::KindSeg, 32767, -32768, -32768, 32767);
    add_pair(spot_pkg::KindRect, 32767, 32767, 32767, 32767,
             spot_pkg::KindRect, -32768, -32768, -32768, -32768);
    add_pair(spot_pkg::KindSeg, 32767, -32768, -32768, 32767,
             spot_pkg::KindSeg, -32768, -32768, 32767, 32767);

    repeat (1000) begin
      add_pair(rnd_kind(), rnd_pos(), rnd_pos(), rnd_size(), rnd_size(),
               rnd_kind(), rnd_pos(), rnd_pos(), rnd_size(), rnd_size());
    end
    n_items = pair_queue.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (flags_seen == n_items);
    repeat (30) @(posedge clk_i);
    if (mismatch_cnt == 0 && overlap_due_q.size() == 0) begin
      $display("shape_pair_overlap_test_tb: clean");
    end else begin
      $display("shape_pair_overlap_test_tb: errors");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("shape_pair_overlap_test_tb: errors");
    $finish;
  end

endmodule
